@@ rtl/core/lru_kvc_pkg.sv @@
// shared types and constants of the lru key-value cache
package lru_kvc_pkg;

	// default geometry
	localparam int ENTRIES_DEF    = 16;
	localparam int KEY_BITS_DEF   = 16;
	localparam int VALUE_BITS_DEF = 16;

	// capacity register
	localparam int            CAP_BITS  = 5;
	localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

	// command codes
	typedef enum logic {
		CMD_GET = 1'b0,
		CMD_PUT = 1'b1
	} cmd_t;

	// update broadcast from the pick logic to every slot
	typedef struct packed {
		logic upd;       // apply an update this cycle
		logic age_all;   // new entry: every valid slot ages by one
		logic set_valid; // target slot becomes valid
		logic wr_key;    // target slot takes the new key
		logic wr_value;  // target slot takes the new value
	} slot_cmd_t;

endpackage

@@ rtl/core/lru_kvc_if.sv @@
// channel interfaces of the lru key-value cache

// request channel: command, key and value
interface lru_kvc_req_if
	import lru_kvc_pkg::*;
#(
	parameter int KEY_BITS   = KEY_BITS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic                  command;
	logic [KEY_BITS-1:0]   key;
	logic [VALUE_BITS-1:0] value;

	modport source (output valid, command, key, value, input ready);
	modport sink   (input valid, command, key, value, output ready);
endinterface

// response channel: one result per request
interface lru_kvc_rsp_if
	import lru_kvc_pkg::*;
#(
	parameter int KEY_BITS   = KEY_BITS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic                  hit;
	logic [VALUE_BITS-1:0] read_value;
	logic                  evicted;
	logic [KEY_BITS-1:0]   evicted_key;

	modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
	modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

// capacity write channel
interface lru_kvc_cfg_if
	import lru_kvc_pkg::*;
;
	logic                valid;
	logic                ready;
	logic [CAP_BITS-1:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

@@ rtl/core/lru_kvc_slot.sv @@
// one cache slot: key, value, valid flag, recency rank and key compare
module lru_kvc_slot
	import lru_kvc_pkg::*;
#(
	parameter int KEY_BITS   = KEY_BITS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	parameter int RANK_BITS  = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  slot_cmd_t             cmd,
	input  logic                  sel,
	input  logic [RANK_BITS-1:0]  old_rank,
	input  logic [KEY_BITS-1:0]   lookup_key,
	input  logic [VALUE_BITS-1:0] wr_value,
	output logic                  valid,
	output logic                  match,
	output logic [RANK_BITS-1:0]  rank,
	output logic [KEY_BITS-1:0]   key,
	output logic [VALUE_BITS-1:0] value
);

	logic                  valid_q;
	logic [RANK_BITS-1:0]  rank_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] value_q;

	// valid flag and recency rank
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= '0;
		end else if (cmd.upd) begin
			if (sel) begin
				rank_q <= '0;
				if (cmd.set_valid) begin
					valid_q <= 1'b1;
				end
			end else if (valid_q && (cmd.age_all || rank_q < old_rank)) begin
				rank_q <= rank_q + RANK_BITS'(1);
			end
		end
	end

	// stored pair, meaningful only while valid
	always_ff @(posedge clk) begin
		if (cmd.upd && sel && cmd.wr_key) begin
			key_q <= lookup_key;
		end
		if (cmd.upd && sel && cmd.wr_value) begin
			value_q <= wr_value;
		end
	end

	assign match = valid_q && (key_q == lookup_key);
	assign valid = valid_q;
	assign rank  = rank_q;
	assign key   = key_q;
	assign value = value_q;

endmodule

@@ rtl/core/lru_kvc_pick.sv @@
// slot selection: hit, free slot or victim, update command and result fields
module lru_kvc_pick
	import lru_kvc_pkg::*;
#(
	parameter  int ENTRIES    = ENTRIES_DEF,
	parameter  int KEY_BITS   = KEY_BITS_DEF,
	parameter  int VALUE_BITS = VALUE_BITS_DEF,
	localparam int RANK_BITS  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
	localparam int OCC_BITS   = $clog2(ENTRIES + 1)
) (
	input  logic                                 active,
	input  logic                                 command,
	input  logic [CAP_BITS-1:0]                  capacity,
	input  logic [OCC_BITS-1:0]                  occupancy,
	input  logic [ENTRIES-1:0]                   valid_vec,
	input  logic [ENTRIES-1:0]                   match_vec,
	input  logic [ENTRIES-1:0][RANK_BITS-1:0]    rank_arr,
	input  logic [ENTRIES-1:0][KEY_BITS-1:0]     key_arr,
	input  logic [ENTRIES-1:0][VALUE_BITS-1:0]   value_arr,
	output logic [ENTRIES-1:0]                   target,
	output slot_cmd_t                            cmd,
	output logic [RANK_BITS-1:0]                 old_rank,
	output logic                                 occ_inc,
	output logic                                 hit,
	output logic [VALUE_BITS-1:0]                read_value,
	output logic                                 evicted,
	output logic [KEY_BITS-1:0]                  evicted_key
);

	localparam int CMP_BITS  = (OCC_BITS > CAP_BITS) ? OCC_BITS : CAP_BITS;

	logic                  is_put;
	logic                  any_hit;
	logic                  room;
	logic                  use_free;
	logic                  do_evict;
	logic [RANK_BITS-1:0]  last_rank;
	logic [ENTRIES-1:0]    hit_oh;
	logic [ENTRIES-1:0]    free_vec;
	logic [ENTRIES-1:0]    free_oh;
	logic [ENTRIES-1:0]    victim_vec;
	logic [ENTRIES-1:0]    victim_oh;
	logic [VALUE_BITS-1:0] hit_value;
	logic [KEY_BITS-1:0]   victim_key;
	logic [RANK_BITS-1:0]  target_rank;

	assign is_put    = (command == CMD_PUT);
	assign any_hit   = |match_vec;
	assign last_rank = RANK_BITS'(occupancy - OCC_BITS'(1));

	// least recent valid slot carries rank occupancy-1
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			victim_vec[i] = valid_vec[i] && (rank_arr[i] == last_rank);
		end
	end

	// lowest-numbered slot of each kind
	assign free_vec  = ~valid_vec;
	assign hit_oh    = match_vec & (~match_vec + ENTRIES'(1));
	assign free_oh   = free_vec & (~free_vec + ENTRIES'(1));
	assign victim_oh = victim_vec & (~victim_vec + ENTRIES'(1));

	// room below the effective capacity (zero counts as one, clipped to the slot count)
	always_comb begin
		if (capacity == '0) begin
			room = (occupancy == '0);
		end else begin
			room = (CMP_BITS'(occupancy) < CMP_BITS'(capacity))
				&& (occupancy != OCC_BITS'(ENTRIES));
		end
	end

	assign use_free = is_put && !any_hit && room && (|free_vec);
	assign do_evict = is_put && !any_hit && !use_free && (|victim_oh);

	// target slot of the update
	always_comb begin
		if (any_hit) begin
			target = hit_oh;
		end else if (use_free) begin
			target = free_oh;
		end else if (do_evict) begin
			target = victim_oh;
		end else begin
			target = '0;
		end
	end

	// one-hot reads of the stored fields
	always_comb begin
		hit_value   = '0;
		victim_key  = '0;
		target_rank = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			hit_value   = hit_value   | (value_arr[i] & {VALUE_BITS{hit_oh[i]}});
			victim_key  = victim_key  | (key_arr[i]   & {KEY_BITS{victim_oh[i]}});
			target_rank = target_rank | (rank_arr[i]  & {RANK_BITS{target[i]}});
		end
	end

	// update broadcast
	always_comb begin
		cmd.upd       = active && (any_hit || is_put);
		cmd.age_all   = use_free;
		cmd.set_valid = use_free;
		cmd.wr_key    = use_free || do_evict;
		cmd.wr_value  = is_put;
	end

	assign old_rank = target_rank;
	assign occ_inc  = active && use_free;

	// result fields
	assign hit         = any_hit;
	assign read_value  = (any_hit && !is_put) ? hit_value : '0;
	assign evicted     = do_evict;
	assign evicted_key = do_evict ? victim_key : '0;

endmodule

@@ rtl/core/lru_key_value_cache.sv @@
// top level of the lru key-value cache: slot array, pick logic and pipeline registers
//
//  channel | role | transfer on          | payload
//  --------+------+----------------------+-------------------------------------------
//  req     | sink | req.valid & ready    | command, key, value
//  rsp     | src  | rsp.valid & ready    | hit, read_value, evicted, evicted_key
//  cfg     | sink | cfg.valid & ready    | data (capacity, always accepted)
//
//  One request per cycle while rsp is not stalled; a request passes the request register
//  and then the result register before its result is presented. The table lookup, slot
//  choice and rank update are done combinationally between those registers, so each
//  request sees the table as left by the one before it.
//  Reset clears all valid flags, ranks and the occupancy count and sets capacity to 16.
//  A stalled rsp holds the result register; req then stalls once the request register is full.
module lru_key_value_cache
	import lru_kvc_pkg::*;
#(
	parameter int ENTRIES    = ENTRIES_DEF,
	parameter int KEY_BITS   = KEY_BITS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	lru_kvc_req_if.sink   req,
	lru_kvc_rsp_if.source rsp,
	lru_kvc_cfg_if.sink   cfg
);

	localparam int RANK_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int OCC_BITS  = $clog2(ENTRIES + 1);

	// request register
	logic                  valid_s1;
	logic                  command_s1;
	logic [KEY_BITS-1:0]   key_s1;
	logic [VALUE_BITS-1:0] value_s1;

	// result register
	logic                  valid_s2;
	logic                  hit_s2;
	logic [VALUE_BITS-1:0] read_value_s2;
	logic                  evicted_s2;
	logic [KEY_BITS-1:0]   evicted_key_s2;

	logic [CAP_BITS-1:0]   capacity_q;
	logic [OCC_BITS-1:0]   occupancy_q;

	logic advance;
	logic process;

	logic [ENTRIES-1:0]                 valid_vec;
	logic [ENTRIES-1:0]                 match_vec;
	logic [ENTRIES-1:0][RANK_BITS-1:0]  rank_arr;
	logic [ENTRIES-1:0][KEY_BITS-1:0]   key_arr;
	logic [ENTRIES-1:0][VALUE_BITS-1:0] value_arr;
	logic [ENTRIES-1:0]                 target;
	slot_cmd_t                          slot_cmd;
	logic [RANK_BITS-1:0]               old_rank;
	logic                               occ_inc;
	logic                               hit_c;
	logic [VALUE_BITS-1:0]              read_value_c;
	logic                               evicted_c;
	logic [KEY_BITS-1:0]                evicted_key_c;

	// flow control
	assign advance   = !valid_s2 || rsp.ready;
	assign process   = valid_s1 && advance;
	assign req.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg.valid && cfg.ready) begin
			capacity_q <= cfg.data;
		end
	end

	// request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			command_s1 <= req.command;
			key_s1     <= req.key;
			value_s1   <= req.value;
		end
	end

	// slot array
	for (genvar g = 0; g < ENTRIES; g++) begin : g_slot
		lru_kvc_slot #(
			.KEY_BITS   (KEY_BITS),
			.VALUE_BITS (VALUE_BITS),
			.RANK_BITS  (RANK_BITS)
		) u_slot (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (slot_cmd),
			.sel        (target[g]),
			.old_rank   (old_rank),
			.lookup_key (key_s1),
			.wr_value   (value_s1),
			.valid      (valid_vec[g]),
			.match      (match_vec[g]),
			.rank       (rank_arr[g]),
			.key        (key_arr[g]),
			.value      (value_arr[g])
		);
	end

	// hit, free slot and victim selection
	lru_kvc_pick #(
		.ENTRIES    (ENTRIES),
		.KEY_BITS   (KEY_BITS),
		.VALUE_BITS (VALUE_BITS)
	) u_pick (
		.active      (process),
		.command     (command_s1),
		.capacity    (capacity_q),
		.occupancy   (occupancy_q),
		.valid_vec   (valid_vec),
		.match_vec   (match_vec),
		.rank_arr    (rank_arr),
		.key_arr     (key_arr),
		.value_arr   (value_arr),
		.target      (target),
		.cmd         (slot_cmd),
		.old_rank    (old_rank),
		.occ_inc     (occ_inc),
		.hit         (hit_c),
		.read_value  (read_value_c),
		.evicted     (evicted_c),
		.evicted_key (evicted_key_c)
	);

	// occupancy count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occupancy_q <= '0;
		end else if (occ_inc) begin
			occupancy_q <= occupancy_q + OCC_BITS'(1);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (process) begin
			hit_s2         <= hit_c;
			read_value_s2  <= read_value_c;
			evicted_s2     <= evicted_c;
			evicted_key_s2 <= evicted_key_c;
		end
	end

	assign rsp.valid       = valid_s2;
	assign rsp.hit         = hit_s2;
	assign rsp.read_value  = read_value_s2;
	assign rsp.evicted     = evicted_s2;
	assign rsp.evicted_key = evicted_key_s2;

	// occupancy never passes the slot count
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occupancy_q <= OCC_BITS'(ENTRIES))
		else $error("occupancy above slot count");

	// occupancy tracks the number of valid slots
	a_occ_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == int'(occupancy_q))
		else $error("occupancy differs from valid slot count");

	// at most one slot is updated
	a_target_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(target))
		else $error("more than one target slot");

	// a put always lands in some slot
	a_put_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(process && command_s1 == CMD_PUT) |-> (|target))
		else $error("put without a target slot");

	// an eviction is never reported together with a hit
	a_evict_miss: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(evicted_s2 && hit_s2))
		else $error("eviction on a hit");

endmodule
